### rtl/core/fractional_power_law_noise_filter_top_macros.svh
// Assertion macros shared by the power-law noise filter RTL.
`ifndef FRACTIONAL_POWER_LAW_NOISE_FILTER_TOP_MACROS_SVH
`define FRACTIONAL_POWER_LAW_NOISE_FILTER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FPLN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FPLN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fpln_pkg.sv
// Package with types and constants of the power-law noise filter.
package fpln_pkg;

    localparam int COEF_BITS    = 24;
    localparam int OUT_BITS     = 24;
    localparam int ALPHA_BITS   = 16;
    localparam int SEQ_LEN_BITS = 9;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int ACC_BITS     = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA      = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEQ_LENGTH = 1'd1;

    localparam logic signed [ALPHA_BITS-1:0] ALPHA_RESET   = 16'sd8192;
    localparam logic [SEQ_LEN_BITS-1:0]      SEQ_LEN_RESET = 9'd256;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = 24'sd4194304;
    localparam logic signed [COEF_BITS-1:0] COEF_MAX = 24'sd8388607;
    localparam logic signed [COEF_BITS-1:0] COEF_MIN = -24'sd8388608;
    localparam logic signed [OUT_BITS-1:0]  OUT_MAX  = 24'sd8388607;
    localparam logic signed [OUT_BITS-1:0]  OUT_MIN  = -24'sd8388608;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMUL,
        S_CABS,
        S_CDIV,
        S_CWRITE,
        S_MAC,
        S_DRAIN,
        S_RND1,
        S_RND2
    } t_state;

endpackage

### rtl/core/fpln_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fpln_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fractional_power_law_noise_filter_top.sv
// Power-law (1/f^alpha) noise filter: the block receives scaled white samples on a slave
// stream and returns one colored sample per input transaction on a master stream.
// Input item n of a sequence first extends the coefficient series by one term
// h[n] = h[n-1] * (alpha/2 + n - 1) / n, then convolves the stored coefficients with the
// stored white history, y[n] = sum h[k] * w[n-k], and rounds the sum to Q9.15.
// One multiplier serves both the coefficient update and the convolution; a bit-serial
// restoring divider finishes the update, and item 0 of a sequence skips the update.
// s_axis_tready is high only while the sequencer is idle, one item at a time.
// A finished result sits in the output register; the next input transaction is taken
// while it waits, and a stalled receiver holds the sequencer only when a second result
// is ready. m_axis_tlast marks the last sample of a sequence of sequence_length items.
// Configuration writes go through i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// make them only while idle, as the block itself does not enforce this.
// Reset empties the output register, sets the sequence index to zero and loads alpha = 1.0
// and sequence_length = 256. The stores need no clearing: every read that is used hits
// an entry that was written earlier in the same sequence.
module fractional_power_law_noise_filter_top #(
    parameter int MAX_LENGTH  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Bits from 0: white_sample (SAMPLE_BITS), then zero fill to whole bytes.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Bits from 0: colored_sample (24).
    output logic [fpln_pkg::OUT_BITS-1:0]         m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  logic                                  i_cfg_we,
    input  logic [fpln_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [fpln_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

`include "fractional_power_law_noise_filter_top_macros.svh"

    localparam int IDXW = $clog2(MAX_LENGTH);
    localparam int NUMW = IDXW + 16;
    localparam int MW   = (NUMW > SAMPLE_BITS) ? NUMW : SAMPLE_BITS;
    localparam int PW   = fpln_pkg::COEF_BITS + MW;
    localparam int QW   = PW + 2 - 14;
    localparam int QCW  = $clog2(QW + 1);
    localparam int CMPW = (IDXW + 1 > fpln_pkg::SEQ_LEN_BITS) ? IDXW + 1
                                                              : fpln_pkg::SEQ_LEN_BITS;
    localparam int ACCW = fpln_pkg::ACC_BITS;

    fpln_pkg::t_state r_state;
    fpln_pkg::t_state n_state;

    logic signed [fpln_pkg::ALPHA_BITS-1:0] r_alpha;
    logic [fpln_pkg::SEQ_LEN_BITS-1:0]      r_seq_len;
    logic [IDXW-1:0]                        r_index;
    logic [IDXW-1:0]                        r_k;
    logic                                   r_rd_v;
    logic                                   r_pr_v;
    logic [QCW-1:0]                         r_div_cnt;
    logic [QW-1:0]                          r_divq;
    logic [IDXW-1:0]                        r_rem;
    logic                                   r_neg;
    logic signed [PW-1:0]                   r_prod;
    logic signed [ACCW-1:0]                 r_acc;
    logic [ACCW-1:0]                        r_omag;
    logic                                   r_oneg;
    logic                                   r_m_valid;
    logic [fpln_pkg::OUT_BITS-1:0]          r_m_data;
    logic                                   r_m_last;

    logic                                   w_in_acc;
    logic                                   w_out_load;
    logic [IDXW-1:0]                        w_coef_raddr;
    logic [IDXW-1:0]                        w_hist_raddr;
    logic                                   w_coef_we;
    logic                                   w_mul_num;
    logic signed [fpln_pkg::COEF_BITS-1:0]  w_coef_rd;
    logic signed [SAMPLE_BITS-1:0]          w_hist_rd;
    logic signed [fpln_pkg::COEF_BITS-1:0]  w_coef_new;
    logic signed [fpln_pkg::COEF_BITS-1:0]  w_coef_wdata;
    logic [IDXW+13:0]                       w_kterm;
    logic signed [NUMW-1:0]                 w_num;
    logic signed [MW-1:0]                   w_mul_b;
    logic signed [PW-1:0]                   w_prod;
    logic signed [PW+1:0]                   w_pext;
    logic [PW+1:0]                          w_mag;
    logic [PW+1:0]                          w_dvd;
    logic [IDXW:0]                          w_rem_sh;
    logic                                   w_ge;
    logic [IDXW:0]                          w_rem_sub;
    logic signed [ACCW:0]                   w_sum;
    logic signed [ACCW-1:0]                 w_acc_next;
    logic [ACCW:0]                          w_osum;
    logic [ACCW-22:0]                       w_oq;
    logic signed [fpln_pkg::OUT_BITS-1:0]   w_y;
    logic [CMPW-1:0]                        w_len_eff;
    logic                                   w_last;

    // Stores.
    fpln_ram #(
        .WIDTH(fpln_pkg::COEF_BITS),
        .DEPTH(MAX_LENGTH)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (w_coef_we),
        .i_waddr(r_index),
        .i_wdata(w_coef_wdata),
        .i_raddr(w_coef_raddr),
        .o_rdata(w_coef_rd)
    );

    fpln_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_LENGTH)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (w_in_acc),
        .i_waddr(r_index),
        .i_wdata(s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_raddr(w_hist_raddr),
        .o_rdata(w_hist_rd)
    );

    assign s_axis_tready = (r_state == fpln_pkg::S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == fpln_pkg::S_RND2) && (!r_m_valid || m_axis_tready);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpln_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (r_index == '0) ? fpln_pkg::S_CWRITE : fpln_pkg::S_CMUL;
                end
            end
            fpln_pkg::S_CMUL:   n_state = fpln_pkg::S_CABS;
            fpln_pkg::S_CABS:   n_state = fpln_pkg::S_CDIV;
            fpln_pkg::S_CDIV: begin
                if (r_div_cnt == QCW'(QW - 1)) begin
                    n_state = fpln_pkg::S_CWRITE;
                end
            end
            fpln_pkg::S_CWRITE: n_state = fpln_pkg::S_MAC;
            fpln_pkg::S_MAC: begin
                if (r_k == r_index) begin
                    n_state = fpln_pkg::S_DRAIN;
                end
            end
            fpln_pkg::S_DRAIN: begin
                if (!r_rd_v && !r_pr_v) begin
                    n_state = fpln_pkg::S_RND1;
                end
            end
            fpln_pkg::S_RND1:   n_state = fpln_pkg::S_RND2;
            fpln_pkg::S_RND2: begin
                if (w_out_load) begin
                    n_state = fpln_pkg::S_IDLE;
                end
            end
            default:            n_state = fpln_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_coef_raddr = r_k;
        w_coef_we    = 1'b0;
        w_mul_num    = 1'b0;
        case (r_state)
            fpln_pkg::S_IDLE:   w_coef_raddr = r_index - 1'b1;
            fpln_pkg::S_CMUL:   w_mul_num    = 1'b1;
            fpln_pkg::S_CWRITE: w_coef_we    = 1'b1;
            default:            w_coef_raddr = r_k;
        endcase
    end

    assign w_hist_raddr = r_index - r_k;

    // Shared multiplier.
    assign w_kterm = {r_index - 1'b1, 14'd0};
    assign w_num   = NUMW'(r_alpha) + $signed({2'b00, w_kterm});
    assign w_mul_b = w_mul_num ? MW'(w_num) : MW'(w_hist_rd);
    assign w_prod  = w_coef_rd * w_mul_b;

    // Magnitude plus half the divisor, scaled down by the fixed power of two.
    assign w_pext = (PW + 2)'(r_prod);
    assign w_mag  = r_prod[PW-1] ? $unsigned(-w_pext) : $unsigned(w_pext);
    assign w_dvd  = w_mag + ((PW + 2)'(r_index) << 13);

    // One restoring divider step per cycle.
    assign w_rem_sh  = {r_rem, r_divq[QW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_index});
    assign w_rem_sub = w_rem_sh - {1'b0, r_index};

    always_comb begin
        if (!r_neg) begin
            w_coef_new = (r_divq > QW'(fpln_pkg::COEF_MAX)) ? fpln_pkg::COEF_MAX
                                                            : r_divq[fpln_pkg::COEF_BITS-1:0];
        end else begin
            w_coef_new = (r_divq > QW'(24'd8388608)) ? fpln_pkg::COEF_MIN
                                                     : -r_divq[fpln_pkg::COEF_BITS-1:0];
        end
    end

    assign w_coef_wdata = (r_index == '0) ? fpln_pkg::COEF_ONE : w_coef_new;

    // Saturating accumulation.
    assign w_sum = (ACCW + 1)'(r_acc) + (ACCW + 1)'(r_prod);
    always_comb begin
        if (w_sum[ACCW] != w_sum[ACCW-1]) begin
            w_acc_next = w_sum[ACCW] ? {1'b1, {(ACCW - 1){1'b0}}} : {1'b0, {(ACCW - 1){1'b1}}};
        end else begin
            w_acc_next = w_sum[ACCW-1:0];
        end
    end

    // Output rounding and saturation.
    assign w_osum = {1'b0, r_omag} + (ACCW + 1)'(22'h200000);
    assign w_oq   = w_osum[ACCW:22];
    always_comb begin
        if (!r_oneg) begin
            w_y = (w_oq > (ACCW - 21)'(fpln_pkg::OUT_MAX)) ? fpln_pkg::OUT_MAX
                                                           : w_oq[fpln_pkg::OUT_BITS-1:0];
        end else begin
            w_y = (w_oq > (ACCW - 21)'(24'd8388608)) ? fpln_pkg::OUT_MIN
                                                     : -w_oq[fpln_pkg::OUT_BITS-1:0];
        end
    end

    always_comb begin
        if (r_seq_len == '0) begin
            w_len_eff = CMPW'(1);
        end else if (CMPW'(r_seq_len) > CMPW'(MAX_LENGTH)) begin
            w_len_eff = CMPW'(MAX_LENGTH);
        end else begin
            w_len_eff = CMPW'(r_seq_len);
        end
    end

    assign w_last = ((CMPW'(r_index) + 1'b1) >= w_len_eff);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fpln_pkg::S_IDLE;
            r_alpha   <= fpln_pkg::ALPHA_RESET;
            r_seq_len <= fpln_pkg::SEQ_LEN_RESET;
            r_index   <= '0;
            r_k       <= '0;
            r_rd_v    <= 1'b0;
            r_pr_v    <= 1'b0;
            r_div_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fpln_pkg::REG_ALPHA:      r_alpha   <= i_cfg_data;
                    fpln_pkg::REG_SEQ_LENGTH: r_seq_len <= i_cfg_data[fpln_pkg::SEQ_LEN_BITS-1:0];
                    default:                  r_alpha   <= r_alpha;
                endcase
            end
            r_rd_v <= (r_state == fpln_pkg::S_MAC);
            r_pr_v <= r_rd_v;
            if (r_state == fpln_pkg::S_CABS) begin
                r_div_cnt <= '0;
            end else if (r_state == fpln_pkg::S_CDIV) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (r_state == fpln_pkg::S_CWRITE) begin
                r_k <= '0;
            end else if (r_state == fpln_pkg::S_MAC) begin
                r_k <= r_k + 1'b1;
            end
            if (w_out_load) begin
                r_index   <= w_last ? '0 : r_index + 1'b1;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_state == fpln_pkg::S_CABS) begin
            r_neg  <= r_prod[PW-1];
            r_divq <= w_dvd[PW+1:14];
            r_rem  <= '0;
        end else if (r_state == fpln_pkg::S_CDIV) begin
            r_divq <= {r_divq[QW-2:0], w_ge};
            r_rem  <= w_ge ? w_rem_sub[IDXW-1:0] : w_rem_sh[IDXW-1:0];
        end
        if (r_state == fpln_pkg::S_CWRITE) begin
            r_acc <= '0;
        end else if (r_pr_v) begin
            r_acc <= w_acc_next;
        end
        if (r_state == fpln_pkg::S_RND1) begin
            r_oneg <= r_acc[ACCW-1];
            r_omag <= r_acc[ACCW-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
        end
        if (w_out_load) begin
            r_m_data <= w_y;
            r_m_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    `FPLN_ASSERT_SAME(a_div_count, i_clk, i_rst_n, r_state == fpln_pkg::S_CDIV,
        r_div_cnt < QCW'(QW), "divider ran past its quotient width")
    `FPLN_ASSERT_SAME(a_mac_range, i_clk, i_rst_n, r_state == fpln_pkg::S_MAC,
        r_k <= r_index, "convolution index passed the current sample")
    `FPLN_ASSERT_SAME(a_drained, i_clk, i_rst_n, r_state == fpln_pkg::S_RND1,
        !r_rd_v && !r_pr_v, "rounding began before the accumulation drained")
    `FPLN_ASSERT_NEXT(a_acc_clear, i_clk, i_rst_n, r_state == fpln_pkg::S_CWRITE,
        r_acc == '0 && r_k == '0, "accumulator not cleared before convolution")

endmodule

### tb/sv/tb_fractional_power_law_noise_filter_top.sv
`timescale 1ns / 100ps
// Testbench for the power-law noise filter, checked against a local model of the filter.
module tb_fractional_power_law_noise_filter_top;

    localparam int DEPTH        = 256;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 850;
    localparam int END_CYCLES   = 320;

    typedef struct packed {
        logic signed [fpln_pkg::OUT_BITS-1:0] colored;
        logic                                 last;
    } t_colored_item;

    typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} t_idle_mode;
    typedef enum int {WHITE_RANDOM, WHITE_SMALL, WHITE_MAX, WHITE_MIN} t_white_style;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // Bits from 0: white_sample (16).
    logic [15:0]                        s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // Bits from 0: colored_sample (24).
    logic [fpln_pkg::OUT_BITS-1:0]      m_axis_tdata;
    logic                               m_axis_tlast;
    logic                               i_cfg_we      = 1'b0;
    logic [fpln_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx     = '0;
    logic [fpln_pkg::CFG_DATA_BITS-1:0] i_cfg_data    = '0;

    logic signed [fpln_pkg::COEF_BITS-1:0]  coef_mem [DEPTH];
    logic signed [15:0]                     white_mem [DEPTH];
    int unsigned                            seq_pos     = 0;
    logic signed [fpln_pkg::ALPHA_BITS-1:0] alpha_q13   = fpln_pkg::ALPHA_RESET;
    logic [fpln_pkg::SEQ_LEN_BITS-1:0]      seq_len_reg = fpln_pkg::SEQ_LEN_RESET;
    t_colored_item                          expected_colored [$];
    int                                     error_count    = 0;
    int                                     idle_cycles    = 0;
    int                                     src_idle_pct   = 0;
    int                                     sink_stall_pct = 0;

    fractional_power_law_noise_filter_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_colored_item filter_sample(input logic signed [15:0] w);
        int unsigned   len;
        int unsigned   n;
        longint        num;
        longint        c;
        longint        acc;
        longint        y;
        t_colored_item r;
        len = 32'(seq_len_reg);
        if (len == 0) len = 1;
        if (len > DEPTH) len = DEPTH;
        n = seq_pos % DEPTH;
        if (n == 0) begin
            coef_mem[0] = fpln_pkg::COEF_ONE;
        end else begin
            num = longint'(alpha_q13) + longint'(n - 1) * 16384;
            c = clamp(div_nearest(longint'(coef_mem[n - 1]) * num, longint'(n) * 16384),
                      fpln_pkg::COEF_MIN, fpln_pkg::COEF_MAX);
            coef_mem[n] = c[fpln_pkg::COEF_BITS-1:0];
        end
        white_mem[n] = w;
        acc = 0;
        for (int k = 0; k <= n; k++) begin
            acc += longint'(coef_mem[k]) * longint'(white_mem[n - k]);
        end
        y = clamp(div_nearest(acc, longint'(1) << 22), fpln_pkg::OUT_MIN, fpln_pkg::OUT_MAX);
        r.colored = y[fpln_pkg::OUT_BITS-1:0];
        r.last = (n + 1 >= len);
        seq_pos = r.last ? 0 : n + 1;
        return r;
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_colored_item want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_colored.size() == 0) begin
                    $error("unexpected output transaction: colored_sample %0d",
                           $signed(m_axis_tdata));
                    error_count++;
                end else begin
                    want = expected_colored.pop_front();
                    if ($signed(m_axis_tdata) !== want.colored) begin
                        $error("colored_sample: expected %0d, actual %0d",
                               want.colored, $signed(m_axis_tdata));
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_sequence: expected %0d, actual %0d",
                               want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_fractional_power_law_noise_filter_top: FAIL");
                $finish;
            end
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SOURCE: begin
                src_idle_pct = 51;
                sink_stall_pct = 0;
            end
            IDLE_SINK: begin
                src_idle_pct = 0;
                sink_stall_pct = 51;
            end
            IDLE_BOTH: begin
                src_idle_pct = 37;
                sink_stall_pct = 37;
            end
            default: begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    task automatic push_white(input logic [15:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_colored.push_back(filter_sample(w));
        @(negedge i_clk);
    endtask

    task automatic stream_white(input int count, input t_white_style style);
        logic [15:0] w;
        for (int i = 0; i < count; i++) begin
            case (style)
                WHITE_MAX:   w = 16'h7FFF;
                WHITE_MIN:   w = 16'h8000;
                WHITE_SMALL: w = 16'($urandom_range(32) - 16);
                default:     w = 16'($urandom);
            endcase
            push_white(w);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_colored.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [fpln_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [fpln_pkg::CFG_DATA_BITS-1:0] value);
        wait_for_results();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == fpln_pkg::REG_ALPHA)
            alpha_q13 = $signed(value);
        else
            seq_len_reg = value[fpln_pkg::SEQ_LEN_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        push_white(16'h7FFF);
        push_white(16'h8000);
        push_white(16'h0000);
        push_white(16'hFFFF);
    endtask

    task automatic test_length_corners();
        // A zero length acts as one and, below the current index, ends the sequence at once.
        write_reg(fpln_pkg::REG_SEQ_LENGTH, 16'h0000);
        stream_white(2, WHITE_RANDOM);
        // Bits above the register width are ignored.
        write_reg(fpln_pkg::REG_SEQ_LENGTH, 16'hFE03);
        stream_white(3, WHITE_RANDOM);
        // A length above the store depth acts as the full depth.
        write_reg(fpln_pkg::REG_SEQ_LENGTH, 16'h012C);
        stream_white(2, WHITE_RANDOM);
        write_reg(fpln_pkg::REG_SEQ_LENGTH, 16'h0001);
        stream_white(2, WHITE_RANDOM);
    endtask

    task automatic test_alpha_corners();
        write_reg(fpln_pkg::REG_SEQ_LENGTH, 16'd8);
        write_reg(fpln_pkg::REG_ALPHA, 16'hC000);
        stream_white(2, WHITE_RANDOM);
        write_reg(fpln_pkg::REG_ALPHA, 16'h4000);
        stream_white(2, WHITE_MAX);
        write_reg(fpln_pkg::REG_ALPHA, 16'h0000);
        stream_white(2, WHITE_RANDOM);
        write_reg(fpln_pkg::REG_ALPHA, 16'h7FFF);
        stream_white(2, WHITE_MIN);
        write_reg(fpln_pkg::REG_ALPHA, 16'h8000);
        stream_white(2, WHITE_RANDOM);
    endtask

    task automatic test_saturation();
        set_idling(IDLE_BOTH);
        write_reg(fpln_pkg::REG_SEQ_LENGTH, 16'd1);
        stream_white(1, WHITE_RANDOM);
        write_reg(fpln_pkg::REG_SEQ_LENGTH, 16'd256);
        write_reg(fpln_pkg::REG_ALPHA, 16'h7FFF);
        stream_white(256, WHITE_MAX);
        stream_white(160, WHITE_MIN);
    endtask

    task automatic test_random_traffic();
        int           phase;
        int           sent;
        int           pick;
        int           eff;
        int           count;
        logic [15:0]  word;
        t_white_style style;
        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_idling(t_idle_mode'(phase % 4));
            if ($urandom_range(3) != 0) begin
                if ($urandom_range(4) == 0)
                    word = 16'($urandom);
                else
                    word = 16'($urandom_range(32768) - 16384);
                write_reg(fpln_pkg::REG_ALPHA, word);
            end
            if ($urandom_range(3) != 0) begin
                pick = $urandom_range(99);
                word = 16'($urandom);
                if (pick < 65)
                    word[8:0] = 9'($urandom_range(16, 1));
                else if (pick < 88)
                    word[8:0] = 9'($urandom_range(64, 17));
                else if (pick < 95)
                    word[8:0] = 9'($urandom_range(256, 65));
                else if (pick < 97)
                    word[8:0] = 9'd0;
                else
                    word[8:0] = 9'($urandom_range(511, 257));
                write_reg(fpln_pkg::REG_SEQ_LENGTH, word);
            end
            eff = (seq_len_reg == 0) ? 1
                : ((int'(seq_len_reg) > DEPTH) ? DEPTH : int'(seq_len_reg));
            count = $urandom_range((eff < 20) ? 3 * eff : 60, 1);
            pick = $urandom_range(99);
            if (pick < 80)
                style = WHITE_RANDOM;
            else if (pick < 90)
                style = WHITE_SMALL;
            else if (pick < 95)
                style = WHITE_MAX;
            else
                style = WHITE_MIN;
            stream_white(count, style);
            sent += count;
            phase++;
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_length_corners();
        test_alpha_corners();
        test_saturation();
        test_random_traffic();
        wait_for_results();
        repeat (END_CYCLES) @(negedge i_clk);
        if (expected_colored.size() != 0) begin
            $error("%0d colored samples never arrived", expected_colored.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_fractional_power_law_noise_filter_top: PASS");
        end else begin
            $display("tb_fractional_power_law_noise_filter_top: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/fpln_pkg.sv
rtl/core/fpln_ram.sv
rtl/core/fractional_power_law_noise_filter_top.sv
tb/sv/tb_fractional_power_law_noise_filter_top.sv
